/* rtl/core/ihip_pkg.sv */
// Package for the image header parser core: parse phases, format codes,
// signature table and byte-insert helpers. No dependencies.
package ihip_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    typedef enum logic [4:0] {
        PH_SIG, PH_DONE, PH_PNG_HDR, PH_PNG_IHDR, PH_PNG_SKIP, PH_PNG_PLTE,
        PH_JPG_FIND, PH_JPG_PAD, PH_JPG_SOF, PH_JPG_LEN, PH_JPG_SKIP, PH_BMP,
        PH_GIF_HDR, PH_GIF_SKIP, PH_GIF_TAG, PH_GIF_LABEL, PH_GIF_BSIZE,
        PH_GIF_BSKIP, PH_GIF_IMG
    } phase_t;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_PNG  = 3'd1;
    localparam logic [2:0] FMT_JPEG = 3'd2;
    localparam logic [2:0] FMT_BMP  = 3'd3;
    localparam logic [2:0] FMT_GIF  = 3'd4;

    localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
    localparam logic [31:0] TAG_PLTE = 32'h504C_5445;
    localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

    // expected signature byte at a given offset
    function automatic logic [7:0] sig_at(logic [2:0] fmt, logic [2:0] off);
        logic [7:0] r;
        r = 8'd0;
        case (fmt)
            FMT_PNG: begin
                case (off)
                    3'd0: r = 8'd137;
                    3'd1: r = 8'd80;
                    3'd2: r = 8'd78;
                    3'd3: r = 8'd71;
                    3'd4: r = 8'd13;
                    3'd5: r = 8'd10;
                    3'd6: r = 8'd26;
                    default: r = 8'd10;
                endcase
            end
            FMT_JPEG: r = (off == 3'd0) ? 8'hFF : (off == 3'd1) ? 8'hD8 : 8'h00;
            FMT_BMP:  r = (off == 3'd0) ? 8'h42 : (off == 3'd1) ? 8'h4D : 8'h00;
            FMT_GIF:  r = (off == 3'd0) ? 8'h47 : (off == 3'd1) ? 8'h49 :
                          (off == 3'd2) ? 8'h46 : 8'h00;
            default:  r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] sig_len(logic [2:0] fmt);
        logic [2:0] r;
        case (fmt)
            FMT_PNG:  r = 3'd0;  // 8, wraps in 3 bits
            FMT_JPEG: r = 3'd2;
            FMT_BMP:  r = 3'd2;
            FMT_GIF:  r = 3'd3;
            default:  r = 3'd1;
        endcase
        return r;
    endfunction

    // OR a byte into a little-endian word at byte position idx
    function automatic logic [31:0] put_byte(logic [31:0] v, logic [1:0] idx,
                                             logic [7:0] b);
        return v | (32'(b) << {idx, 3'b000});
    endfunction

endpackage

/* rtl/core/image_header_info_parser_core.sv */
// Image header parser core: one byte per beat, one result beat per file.
// Depends on ihip_pkg.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_byte_in, s_last_byte
//  m_      | out       | m_valid / m_ready  | m_format, m_success, m_width,
//          |           |                    | m_height, m_bits_per_pixel, m_colors
//
// One byte beat per cycle unless stalled; the parse state updates in the cycle
// of the beat. The result register loads on the deciding byte (or on the last
// byte) and shows the beat in the next cycle. s_ready is low only while a result
// waits with m_ready low. Synchronous active-low reset clears the parse state.
// The PLTE length / 3 comes from a reciprocal multiply registered each cycle.
module image_header_info_parser_core #(
    parameter int LENGTH_BITS = ihip_pkg::LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_format,
    output logic        m_success,
    output logic [30:0] m_width,
    output logic [30:0] m_height,
    output logic [15:0] m_bits_per_pixel,
    output logic [31:0] m_colors
);
    import ihip_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [2:0]             fmt_reg, fmt_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next;
    logic [LENGTH_BITS-1:0] skip_reg, skip_next;
    logic [3:0]             fs_reg, fs_next;
    logic [31:0]            seg_reg, seg_next;
    logic [31:0]            tag_reg, tag_next;
    logic [31:0]            wid_reg, wid_next;
    logic [31:0]            hgt_reg, hgt_next;
    logic [15:0]            bpp_reg, bpp_next;
    logic [31:0]            col_reg, col_next;
    logic [7:0]             gflags_reg, gflags_next;
    logic                   dec_reg, dec_next;
    logic [31:0]            div3_reg;
    logic [63:0]            div3_prod;

    logic                   m_valid_reg;
    logic [2:0]             m_format_reg;
    logic                   m_success_reg;
    logic [30:0]            m_width_reg, m_height_reg;
    logic [15:0]            m_bpp_reg;
    logic [31:0]            m_colors_reg;

    logic        accept, emit_hit, emit_ok, good;
    logic [2:0]  emit_fmt;
    logic [7:0]  b;
    logic [5:0]  off6;
    logic        off_small;
    logic [32:0] seg_plus4;
    logic [9:0]  gif_col;
    logic [11:0] gif_col3;
    logic [23:0] jpg_prod;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign b         = s_byte_in;
    assign off6      = off_reg[5:0];
    assign off_small = (off_reg < LENGTH_BITS'(64));
    assign seg_plus4 = {1'b0, seg_reg} + 33'd4;
    assign gif_col   = 10'd2 << gflags_reg[2:0];
    assign gif_col3  = 12'(gif_col) * 12'd3;
    assign jpg_prod  = bpp_reg * 24'(b);
    assign div3_prod = 64'(seg_reg) * 64'(DIV3_RECIP);

    always_comb begin
        phase_next  = phase_reg;
        fmt_next    = fmt_reg;
        off_next    = (off_reg != LEN_MAX) ? off_reg + 1'b1 : off_reg;
        skip_next   = skip_reg;
        fs_next     = fs_reg;
        seg_next    = seg_reg;
        tag_next    = tag_reg;
        wid_next    = wid_reg;
        hgt_next    = hgt_reg;
        bpp_next    = bpp_reg;
        col_next    = col_reg;
        gflags_next = gflags_reg;
        dec_next    = dec_reg;
        emit_hit    = 1'b0;
        emit_ok     = 1'b0;

        if (!dec_reg) begin
            case (phase_reg)
                PH_SIG: begin
                    if (off_reg == '0) begin
                        if (b == 8'd137)      fmt_next = FMT_PNG;
                        else if (b == 8'hFF)  fmt_next = FMT_JPEG;
                        else if (b == 8'h42)  fmt_next = FMT_BMP;
                        else if (b == 8'h47)  fmt_next = FMT_GIF;
                        else begin
                            fmt_next = FMT_NONE;
                            emit_hit = 1'b1;
                        end
                    end else if (off_reg >= LENGTH_BITS'(8) ||
                                 b != sig_at(fmt_reg, off_reg[2:0])) begin
                        fmt_next = FMT_NONE;
                        emit_hit = 1'b1;
                    end else if (off_reg[2:0] + 3'd1 == sig_len(fmt_reg)) begin
                        fs_next = '0;
                        case (fmt_reg)
                            FMT_PNG:  phase_next = PH_PNG_HDR;
                            FMT_JPEG: phase_next = PH_JPG_FIND;
                            FMT_BMP:  phase_next = PH_BMP;
                            default:  phase_next = PH_GIF_HDR;
                        endcase
                    end
                end
                PH_PNG_HDR: begin
                    if (fs_reg < 4'd4) seg_next = {seg_reg[23:0], b};
                    else               tag_next = {tag_reg[23:0], b};
                    fs_next = fs_reg + 4'd1;
                    if (fs_reg == 4'd7) begin
                        fs_next = '0;
                        if (tag_next == TAG_IHDR) begin
                            if (seg_reg != 32'd13) emit_hit = 1'b1;
                            else begin
                                wid_next   = '0;
                                hgt_next   = '0;
                                bpp_next   = '0;
                                phase_next = PH_PNG_IHDR;
                            end
                        end else if (off_reg == LENGTH_BITS'(15)) begin
                            emit_hit = 1'b1;
                        end else if (tag_next == TAG_PLTE) begin
                            col_next   = div3_reg;
                            skip_next  = LENGTH_BITS'(4);
                            phase_next = PH_PNG_PLTE;
                        end else begin
                            skip_next  = (seg_plus4 > 33'(LEN_MAX)) ? LEN_MAX
                                                               : LENGTH_BITS'(seg_plus4);
                            phase_next = PH_PNG_SKIP;
                        end
                    end
                end
                PH_PNG_IHDR: begin
                    if (fs_reg < 4'd4)       wid_next = {wid_reg[23:0], b};
                    else if (fs_reg < 4'd8)  hgt_next = {hgt_reg[23:0], b};
                    else if (fs_reg == 4'd8) bpp_next = 16'(b);
                    fs_next = fs_reg + 4'd1;
                    if (fs_reg == 4'd9) begin
                        fs_next  = '0;
                        emit_hit = 1'b1;
                        emit_ok  = 1'b1;
                        case (b)
                            8'd0: bpp_next = bpp_reg;
                            8'd2: bpp_next = 16'(bpp_reg * 16'd3);
                            8'd3: begin
                                bpp_next   = 16'd24;
                                emit_hit   = 1'b0;
                                skip_next  = LENGTH_BITS'(7);
                                phase_next = PH_PNG_SKIP;
                            end
                            8'd4: bpp_next = 16'(bpp_reg * 16'd2);
                            8'd6: bpp_next = 16'(bpp_reg * 16'd4);
                            default: emit_ok = 1'b0;
                        endcase
                    end
                end
                PH_PNG_SKIP: begin
                    if (skip_reg != '0) skip_next = skip_reg - 1'b1;
                    if (skip_next == '0) begin
                        fs_next    = '0;
                        phase_next = PH_PNG_HDR;
                    end
                end
                PH_PNG_PLTE: begin
                    if (skip_reg != '0) skip_next = skip_reg - 1'b1;
                    if (skip_next == '0) begin
                        emit_hit = 1'b1;
                        emit_ok  = 1'b1;
                    end
                end
                PH_JPG_FIND: begin
                    if (b == 8'hFF) phase_next = PH_JPG_PAD;
                end
                PH_JPG_PAD: begin
                    if (b != 8'hFF) begin
                        fs_next  = '0;
                        seg_next = '0;
                        if (b[7:4] == 4'hC && b != 8'hC4 && b != 8'hC8 && b != 8'hCC)
                            phase_next = PH_JPG_SOF;
                        else if (b == 8'hDA || b == 8'hD9)
                            emit_hit = 1'b1;
                        else
                            phase_next = PH_JPG_LEN;
                    end
                end
                PH_JPG_SOF: begin
                    fs_next = fs_reg + 4'd1;
                    if (fs_reg < 4'd2) begin
                        seg_next = {seg_reg[23:0], b};
                        if (fs_reg == 4'd1 && seg_next < 32'd8) emit_hit = 1'b1;
                    end else if (fs_reg == 4'd2) begin
                        bpp_next = 16'(b);
                    end else if (fs_reg < 4'd5) begin
                        hgt_next = {hgt_reg[23:0], b};
                    end else if (fs_reg < 4'd7) begin
                        wid_next = {wid_reg[23:0], b};
                    end else begin
                        bpp_next = jpg_prod[15:0];
                        col_next = '0;
                        emit_hit = 1'b1;
                        emit_ok  = 1'b1;
                    end
                end
                PH_JPG_LEN: begin
                    seg_next = {seg_reg[23:0], b};
                    fs_next  = fs_reg + 4'd1;
                    if (fs_reg != 4'd0) begin
                        if (seg_next < 32'd2) emit_hit = 1'b1;
                        else begin
                            skip_next  = LENGTH_BITS'(seg_next - 32'd2);
                            phase_next = (seg_next != 32'd2) ? PH_JPG_SKIP : PH_JPG_FIND;
                        end
                    end
                end
                PH_JPG_SKIP: begin
                    if (skip_reg != '0) skip_next = skip_reg - 1'b1;
                    if (skip_next == '0) phase_next = PH_JPG_FIND;
                end
                PH_BMP: begin
                    if (off_small && off6 >= 6'd14 && off6 <= 6'd17) begin
                        seg_next = put_byte(seg_reg, 2'(off6 - 6'd14), b);
                    end else if (off_reg >= LENGTH_BITS'(18) && seg_reg == 32'd12) begin
                        if (off_small && off6 <= 6'd19)
                            wid_next = put_byte(wid_reg, 2'(off6 - 6'd18), b);
                        else if (off_small && off6 <= 6'd21)
                            hgt_next = put_byte(hgt_reg, 2'(off6 - 6'd20), b);
                        else if (off_small && (off6 == 6'd24 || off6 == 6'd25)) begin
                            bpp_next = 16'(put_byte(32'(bpp_reg), 2'(off6 - 6'd24), b));
                            if (off6 == 6'd25) begin
                                col_next = (bpp_next <= 16'd8) ? 32'd1 << bpp_next[3:0]
                                                               : 32'd0;
                                emit_hit = 1'b1;
                                emit_ok  = 1'b1;
                            end
                        end
                    end else if (off_reg >= LENGTH_BITS'(18)) begin
                        if (off_small && off6 <= 6'd21)
                            wid_next = put_byte(wid_reg, 2'(off6 - 6'd18), b);
                        else if (off_small && off6 <= 6'd25)
                            hgt_next = put_byte(hgt_reg, 2'(off6 - 6'd22), b);
                        else if (off_small && (off6 == 6'd28 || off6 == 6'd29))
                            bpp_next = 16'(put_byte(32'(bpp_reg), 2'(off6 - 6'd28), b));
                        else if (off_small && off6 >= 6'd46 && off6 <= 6'd49) begin
                            col_next = put_byte(col_reg, 2'(off6 - 6'd46), b);
                            if (off6 == 6'd49) begin
                                if (bpp_reg <= 16'd8)
                                    col_next = (col_next != '0) ? col_next
                                                                : 32'd1 << bpp_reg[3:0];
                                else
                                    col_next = '0;
                                emit_hit = 1'b1;
                                emit_ok  = 1'b1;
                            end
                        end
                    end
                end
                PH_GIF_HDR: begin
                    if ((off_reg == LENGTH_BITS'(3) && b != 8'h38) ||
                        (off_reg == LENGTH_BITS'(4) && b != 8'h37 && b != 8'h39) ||
                        (off_reg == LENGTH_BITS'(5) && b != 8'h61)) begin
                        emit_hit = 1'b1;
                    end else begin
                        if (off_reg == LENGTH_BITS'(10)) gflags_next = b;
                        if (off_reg == LENGTH_BITS'(12)) begin
                            col_next = 32'(gif_col);
                            bpp_next = 16'd3 * (16'(gflags_reg[6:4]) + 16'd1);
                            if (gflags_reg[7]) begin
                                skip_next  = LENGTH_BITS'(gif_col3);
                                phase_next = PH_GIF_SKIP;
                            end else begin
                                phase_next = PH_GIF_TAG;
                            end
                        end
                    end
                end
                PH_GIF_SKIP: begin
                    if (skip_reg != '0) skip_next = skip_reg - 1'b1;
                    if (skip_next == '0) phase_next = PH_GIF_TAG;
                end
                PH_GIF_TAG: begin
                    if (b == 8'h21) phase_next = PH_GIF_LABEL;
                    else if (b == 8'h2C) begin
                        fs_next    = '0;
                        wid_next   = '0;
                        hgt_next   = '0;
                        phase_next = PH_GIF_IMG;
                    end else emit_hit = 1'b1;
                end
                PH_GIF_LABEL: phase_next = PH_GIF_BSIZE;
                PH_GIF_BSIZE: begin
                    if (b == 8'd0) phase_next = PH_GIF_TAG;
                    else begin
                        skip_next  = LENGTH_BITS'(b);
                        phase_next = PH_GIF_BSKIP;
                    end
                end
                PH_GIF_BSKIP: begin
                    if (skip_reg != '0) skip_next = skip_reg - 1'b1;
                    if (skip_next == '0) phase_next = PH_GIF_BSIZE;
                end
                PH_GIF_IMG: begin
                    if (fs_reg == 4'd4 || fs_reg == 4'd5)
                        wid_next = put_byte(wid_reg, 2'(fs_reg - 4'd4), b);
                    else if (fs_reg == 4'd6 || fs_reg == 4'd7)
                        hgt_next = put_byte(hgt_reg, 2'(fs_reg - 4'd6), b);
                    if (fs_reg == 4'd7) begin
                        emit_hit = 1'b1;
                        emit_ok  = 1'b1;
                    end else fs_next = fs_reg + 4'd1;
                end
                default: ;
            endcase
            if (emit_hit) begin
                dec_next   = 1'b1;
                phase_next = PH_DONE;
            end
        end

        emit_fmt = fmt_next;
        // file ends undecided: failure beat
        if (s_last_byte && !dec_next) begin
            emit_hit = 1'b1;
            emit_ok  = 1'b0;
            if (phase_next == PH_SIG) emit_fmt = FMT_NONE;
        end
        good = emit_ok && wid_next != '0 && !wid_next[31] && hgt_next != '0 && !hgt_next[31];
    end

    always_ff @(posedge aclk) begin
        div3_reg <= {1'b0, div3_prod[63:33]};
        if (!aresetn || (accept && s_last_byte)) begin
            phase_reg  <= PH_SIG;
            fmt_reg    <= FMT_NONE;
            off_reg    <= '0;
            skip_reg   <= '0;
            fs_reg     <= '0;
            seg_reg    <= '0;
            tag_reg    <= '0;
            wid_reg    <= '0;
            hgt_reg    <= '0;
            bpp_reg    <= '0;
            col_reg    <= '0;
            gflags_reg <= '0;
            dec_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            fmt_reg    <= fmt_next;
            off_reg    <= off_next;
            skip_reg   <= skip_next;
            fs_reg     <= fs_next;
            seg_reg    <= seg_next;
            tag_reg    <= tag_next;
            wid_reg    <= wid_next;
            hgt_reg    <= hgt_next;
            bpp_reg    <= bpp_next;
            col_reg    <= col_next;
            gflags_reg <= gflags_next;
            dec_reg    <= dec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit_hit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept && emit_hit) begin
            m_format_reg  <= emit_fmt;
            m_success_reg <= good;
            m_width_reg   <= good ? wid_next[30:0] : '0;
            m_height_reg  <= good ? hgt_next[30:0] : '0;
            m_bpp_reg     <= good ? bpp_next : '0;
            m_colors_reg  <= good ? col_next : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_format         = m_format_reg;
    assign m_success        = m_success_reg;
    assign m_width          = m_width_reg;
    assign m_height         = m_height_reg;
    assign m_bits_per_pixel = m_bpp_reg;
    assign m_colors         = m_colors_reg;

endmodule

/* rtl/core/ihip_checker.sv */
// Port-level checks, bound into every instance of the image header parser core.
// Depends on ihip_pkg and the core's port list.
module ihip_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_format,
    input logic        m_success,
    input logic [30:0] m_width,
    input logic [30:0] m_height,
    input logic [15:0] m_bits_per_pixel,
    input logic [31:0] m_colors
);
    import ihip_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_width) && $stable(m_format))
        else $error("result beat changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_success |-> m_width == '0 && m_height == '0 &&
                                  m_bits_per_pixel == '0 && m_colors == '0)
        else $error("failed result carries data");

    a_ok_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_success |-> m_format != FMT_NONE && m_width != '0 && m_height != '0)
        else $error("success without format or size");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind image_header_info_parser_core ihip_checker u_ihip_checker (.*);
